@@ rtl/rpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Running mean package
// Widths, defaults and shared types for the per-channel running mean core.
// ----------------------------------------------------------------------------
package rpm_pkg;

   localparam int ENERGY_W    = 16;
   localparam int TIMING_W    = 32;
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 32;
   localparam int MEAN_W      = 24;
   localparam int APDS        = 2;

   localparam int DEF_NUM_CARTRIDGES = 2;
   localparam int DEF_NUM_FINS       = 8;
   localparam int DEF_NUM_MODULES    = 16;
   localparam int DEF_FRAC_BITS      = 8;

   localparam int MEAN_MAX = 2 ** (MEAN_W - 1) - 1;
   localparam int MEAN_MIN = -(2 ** (MEAN_W - 1));

   localparam logic [COUNT_W-1:0]         COUNT_MAX       = '1;
   localparam logic signed [ENERGY_W-1:0] THRESHOLD_RESET = -16'sd700;

   // One channel's stored statistics.
   typedef struct packed {
      logic [COUNT_W-1:0]       hit_count;
      logic signed [MEAN_W-1:0] u_mean;
      logic signed [MEAN_W-1:0] v_mean;
   } entry_type;

endpackage

@@ rtl/rpm_channel_if.sv @@
// ----------------------------------------------------------------------------
// Running mean channels
// Valid/ready channels for detector events and for per-event results.
// ----------------------------------------------------------------------------
interface rpm_req_if import rpm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ENERGY_W-1:0] energy;
   logic                       cartridge_index;
   logic [2:0]                 fin_index;
   logic [3:0]                 module_index;
   logic                       apd_index;
   logic [TIMING_W-1:0]        timing_word;

   modport source (
      output valid, energy, cartridge_index, fin_index, module_index, apd_index,
             timing_word,
      input  ready
   );
   modport sink (
      input  valid, energy, cartridge_index, fin_index, module_index, apd_index,
             timing_word,
      output ready
   );
endinterface

interface rpm_rsp_if import rpm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic [COUNT_W-1:0]       hit_count;
   logic signed [MEAN_W-1:0] u_average;
   logic signed [MEAN_W-1:0] v_average;

   modport source (
      output valid, accepted, hit_count, u_average, v_average,
      input  ready
   );
   modport sink (
      input  valid, accepted, hit_count, u_average, v_average,
      output ready
   );
endinterface

@@ rtl/rpm_table.sv @@
// ----------------------------------------------------------------------------
// Running mean channel table
// One-write, one-read memory of per-channel counts and means, registered read.
// ----------------------------------------------------------------------------
module rpm_table import rpm_pkg::*; #(
   parameter  int DEPTH  = 512,
   localparam int AddrW  = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rpm_div.sv @@
// ----------------------------------------------------------------------------
// Running mean divider
// Restoring divider, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module rpm_div import rpm_pkg::*; #(
   parameter int DIVIDEND_W = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   input  logic [COUNT_W-1:0]           divisor,
   output logic                         done,
   output logic signed [DIVIDEND_W-1:0] quotient
);

   localparam int IterW = $clog2(DIVIDEND_W);

   logic                         busy_ff, busy_in;
   logic                         fin_ff, fin_in;
   logic                         done_ff, done_in;
   logic [IterW-1:0]             iter_ff, iter_in;
   logic                         neg_ff, neg_in;
   logic [DIVIDEND_W-1:0]        mag_ff, mag_in;
   logic [COUNT_W:0]             rem_ff, rem_in;
   logic [COUNT_W-1:0]           divisor_ff, divisor_in;
   logic signed [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [COUNT_W:0]             rem_shift;
   logic                         fits;

   // The remainder stays below the divisor, so its top bit is free for the shift.
   assign rem_shift = {rem_ff[COUNT_W-1:0], mag_ff[DIVIDEND_W-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      fin_in     = 1'b0;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         iter_in    = '0;
         neg_in     = dividend[DIVIDEND_W-1];
         mag_in     = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_shift - {1'b0, divisor_ff} : rem_shift;
         mag_in  = {mag_ff[DIVIDEND_W-2:0], fits};
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IterW'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         quot_in = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff    <= iter_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < {1'b0, divisor_ff})
      else $error("divider remainder reached the divisor");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !fin_ff)
      else $error("divider started while a division was in flight");

   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(fin_ff) && !busy_ff)
      else $error("divider done without a finishing cycle");

endmodule

@@ rtl/per_channel_running_mean_core.sv @@
// ----------------------------------------------------------------------------
// Per-channel running mean core
// Keeps per-channel hit counts and running means of the u and v timing samples.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  req_bus  in         valid/ready          energy, channel address, timing word
//  rsp_bus  out        valid/ready          accepted, hit_count, u/v averages
//  csr_*    in         write enable only    energy threshold
//
//  An accepted, in-range event uses the shared divider, which produces one quotient
//  bit per cycle and runs once for u and once for v. Rejected and out-of-range
//  events skip the divider.
//  After reset the channel table is cleared one entry per cycle (all DEPTH entries,
//  512 by default) while req_bus.ready stays low.
//  A new event is taken while an earlier result waits on rsp_bus.
// ----------------------------------------------------------------------------
module per_channel_running_mean_core import rpm_pkg::*; #(
   parameter int NUM_CARTRIDGES = DEF_NUM_CARTRIDGES,
   parameter int NUM_FINS       = DEF_NUM_FINS,
   parameter int NUM_MODULES    = DEF_NUM_MODULES,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   rpm_req_if.sink                    req_bus,
   rpm_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic signed [ENERGY_W-1:0] csr_write_data
);

   localparam int DEPTH = NUM_CARTRIDGES * NUM_FINS * NUM_MODULES * APDS;
   localparam int AddrW = $clog2(DEPTH);
   localparam int DiffW = ((SAMPLE_W + FRAC_BITS) > MEAN_W ?
                           (SAMPLE_W + FRAC_BITS) : MEAN_W) + 1;

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_READ    = 10'b00_0000_0100,
      ST_CALC    = 10'b00_0000_1000,
      ST_START_U = 10'b00_0001_0000,
      ST_WAIT_U  = 10'b00_0010_0000,
      ST_START_V = 10'b00_0100_0000,
      ST_WAIT_V  = 10'b00_1000_0000,
      ST_WRITE   = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } state_type;

   function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [DiffW:0] s);
      priority if (s > (DiffW+1)'(MEAN_MAX)) begin
         return MEAN_W'(MEAN_MAX);
      end else if (s < (DiffW+1)'(MEAN_MIN)) begin
         return MEAN_W'(MEAN_MIN);
      end else begin
         return MEAN_W'(s);
      end
   endfunction

   state_type                  state_ff, state_in;
   logic signed [ENERGY_W-1:0] threshold_ff, threshold_in;
   logic [AddrW-1:0]           clr_addr_ff, clr_addr_in;
   logic [AddrW-1:0]           addr_ff, addr_in;
   logic                       accept_ff, accept_in;
   logic signed [SAMPLE_W-1:0] u_sample_ff, u_sample_in;
   logic signed [SAMPLE_W-1:0] v_sample_ff, v_sample_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [MEAN_W-1:0]   u_mean_ff, u_mean_in;
   logic signed [MEAN_W-1:0]   v_mean_ff, v_mean_in;
   logic signed [DiffW-1:0]    diff_ff, diff_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_accepted_ff, rsp_accepted_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic signed [MEAN_W-1:0]   rsp_u_ff, rsp_u_in;
   logic signed [MEAN_W-1:0]   rsp_v_ff, rsp_v_in;

   logic                    in_range;
   logic [AddrW-1:0]        req_addr;
   logic                    tbl_we;
   logic [AddrW-1:0]        tbl_wr_addr;
   entry_type               tbl_wr_data;
   logic                    tbl_re;
   entry_type               tbl_rd_data;
   logic                    div_start;
   logic                    div_done;
   logic signed [DiffW-1:0] div_quot;
   logic [COUNT_W-1:0]      count_next;
   logic signed [DiffW-1:0] u_scaled;
   logic signed [DiffW-1:0] v_scaled;
   logic signed [DiffW:0]   mean_sum;

   assign in_range = (int'(req_bus.cartridge_index) < NUM_CARTRIDGES) &&
                     (int'(req_bus.fin_index) < NUM_FINS) &&
                     (int'(req_bus.module_index) < NUM_MODULES);
   assign req_addr = AddrW'(((int'(req_bus.cartridge_index) * NUM_FINS +
                              int'(req_bus.fin_index)) * NUM_MODULES +
                             int'(req_bus.module_index)) * APDS +
                            int'(req_bus.apd_index));

   assign u_scaled   = DiffW'(u_sample_ff) <<< FRAC_BITS;
   assign v_scaled   = DiffW'(v_sample_ff) <<< FRAC_BITS;
   assign count_next = (tbl_rd_data.hit_count == COUNT_MAX) ? tbl_rd_data.hit_count :
                       tbl_rd_data.hit_count + COUNT_W'(1);
   assign mean_sum   = (state_ff == ST_WAIT_U) ?
                       (DiffW+1)'(u_mean_ff) + (DiffW+1)'(div_quot) :
                       (DiffW+1)'(v_mean_ff) + (DiffW+1)'(div_quot);

   assign tbl_we      = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign tbl_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign tbl_wr_data = (state_ff == ST_CLEAR) ? '0 :
                        entry_type'{hit_count: count_ff, u_mean: u_mean_ff,
                                    v_mean: v_mean_ff};
   assign tbl_re      = (state_ff == ST_READ);
   assign div_start   = (state_ff == ST_START_U) || (state_ff == ST_START_V);

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.accepted  = rsp_accepted_ff;
   assign rsp_bus.hit_count = rsp_count_ff;
   assign rsp_bus.u_average = rsp_u_ff;
   assign rsp_bus.v_average = rsp_v_ff;

   always_comb begin
      state_in        = state_ff;
      threshold_in    = csr_write_enable ? csr_write_data : threshold_ff;
      clr_addr_in     = clr_addr_ff;
      addr_in         = addr_ff;
      accept_in       = accept_ff;
      u_sample_in     = u_sample_ff;
      v_sample_in     = v_sample_ff;
      count_in        = count_ff;
      u_mean_in       = u_mean_ff;
      v_mean_in       = v_mean_ff;
      diff_in         = diff_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_u_in        = rsp_u_ff;
      rsp_v_in        = rsp_v_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AddrW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               addr_in     = req_addr;
               accept_in   = in_range && (req_bus.energy < threshold_ff);
               u_sample_in = req_bus.timing_word[TIMING_W-1:SAMPLE_W];
               v_sample_in = req_bus.timing_word[SAMPLE_W-1:0];
               if (in_range) begin
                  state_in = ST_READ;
               end else begin
                  // An unknown channel reports zeros and leaves the table alone.
                  count_in  = '0;
                  u_mean_in = '0;
                  v_mean_in = '0;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            count_in  = accept_ff ? count_next : tbl_rd_data.hit_count;
            u_mean_in = tbl_rd_data.u_mean;
            v_mean_in = tbl_rd_data.v_mean;
            diff_in   = u_scaled - DiffW'(tbl_rd_data.u_mean);
            state_in  = accept_ff ? ST_START_U : ST_DONE;
         end
         ST_START_U: begin
            state_in = ST_WAIT_U;
         end
         ST_WAIT_U: begin
            if (div_done) begin
               u_mean_in = sat_mean(mean_sum);
               diff_in   = v_scaled - DiffW'(v_mean_ff);
               state_in  = ST_START_V;
            end
         end
         ST_START_V: begin
            state_in = ST_WAIT_V;
         end
         ST_WAIT_V: begin
            if (div_done) begin
               v_mean_in = sat_mean(mean_sum);
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = accept_ff;
               rsp_count_in    = count_ff;
               rsp_u_in        = u_mean_ff;
               rsp_v_in        = v_mean_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         threshold_ff <= THRESHOLD_RESET;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff         <= addr_in;
      accept_ff       <= accept_in;
      u_sample_ff     <= u_sample_in;
      v_sample_ff     <= v_sample_in;
      count_ff        <= count_in;
      u_mean_ff       <= u_mean_in;
      v_mean_ff       <= v_mean_in;
      diff_ff         <= diff_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_u_ff        <= rsp_u_in;
      rsp_v_ff        <= rsp_v_in;
   end

   rpm_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_re),
      .rd_addr (addr_ff),
      .rd_data (tbl_rd_data)
   );

   rpm_div #(
      .DIVIDEND_W (DiffW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   a_write_only_when_updating: assert property (@(posedge clock) disable iff (reset)
      tbl_we && (state_ff != ST_CLEAR) |-> accept_ff)
      else $error("table written for an event that was not accepted");

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT_U) || (state_ff == ST_WAIT_V))
      else $error("divider result arrived outside a wait state");

   a_accepted_has_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_accepted_ff |-> rsp_count_ff != '0)
      else $error("accepted event reported with a zero count");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> count_ff != '0)
      else $error("division started with a zero count");

endmodule

@@ verif/tb_per_channel_running_mean_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel running mean core testbench
// Sends detector events under several energy thresholds and checks each
// result against a cycle-free predictor of the channel counts and means.
// Both sides of the core stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_per_channel_running_mean_core;
   import rpm_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int TABLE_DEPTH   = DEF_NUM_CARTRIDGES * DEF_NUM_FINS * DEF_NUM_MODULES * APDS;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 100;
   localparam int PRINT_LIMIT   = 40;
   localparam int HOT_CHANNELS  = 6;

   typedef struct {
      logic signed [ENERGY_W-1:0] energy;
      logic                       cartridge_index;
      logic [2:0]                 fin_index;
      logic [3:0]                 module_index;
      logic                       apd_index;
      logic [TIMING_W-1:0]        timing_word;
   } event_type;

   typedef struct {
      logic                     accepted;
      logic [COUNT_W-1:0]       hit_count;
      logic signed [MEAN_W-1:0] u_average;
      logic signed [MEAN_W-1:0] v_average;
   } result_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic signed [ENERGY_W-1:0] csr_write_data;

   rpm_req_if req_bus ();
   rpm_rsp_if rsp_bus ();

   per_channel_running_mean_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predicted channel statistics and the threshold the core should hold.
   logic [COUNT_W-1:0]         chan_hits   [TABLE_DEPTH];
   logic signed [MEAN_W-1:0]   chan_u_mean [TABLE_DEPTH];
   logic signed [MEAN_W-1:0]   chan_v_mean [TABLE_DEPTH];
   logic signed [ENERGY_W-1:0] threshold_shadow;

   result_type pending_results[$];

   int  error_count     = 0;
   int  events_sent     = 0;
   int  results_checked = 0;
   int  updates_seen    = 0;
   int  cycle_count     = 0;
   bit  quiet_sender    = 1'b0;
   bit  quiet_receiver  = 1'b0;
   int  hot_channels [HOT_CHANNELS];

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // One step of mean += (x - mean) / count, quotient truncated toward zero.
   function automatic logic signed [MEAN_W-1:0] advance_mean(
      input logic signed [MEAN_W-1:0]   mean,
      input logic signed [SAMPLE_W-1:0] sample,
      input logic [COUNT_W-1:0]         count
   );
      longint scaled, delta, next;
      scaled = longint'(sample) * (longint'(1) << DEF_FRAC_BITS);
      delta  = scaled - longint'(mean);
      next   = longint'(mean) + delta / longint'(count);
      if (next > MEAN_MAX) next = MEAN_MAX;
      if (next < MEAN_MIN) next = MEAN_MIN;
      return next[MEAN_W-1:0];
   endfunction

   // With the default table size every address field value is in range,
   // so the packed field bits are the table address.
   function automatic result_type apply_event(input event_type ev);
      result_type         r;
      int                 addr;
      logic [COUNT_W-1:0] hits;
      addr = int'({ev.cartridge_index, ev.fin_index, ev.module_index, ev.apd_index});
      r.accepted = 1'b0;
      if (ev.energy < threshold_shadow) begin
         hits = chan_hits[addr];
         if (hits != COUNT_MAX) hits++;
         chan_hits[addr]   = hits;
         chan_u_mean[addr] = advance_mean(chan_u_mean[addr],
                                          $signed(ev.timing_word[31:16]), hits);
         chan_v_mean[addr] = advance_mean(chan_v_mean[addr],
                                          $signed(ev.timing_word[15:0]), hits);
         r.accepted = 1'b1;
      end
      r.hit_count = chan_hits[addr];
      r.u_average = chan_u_mean[addr];
      r.v_average = chan_v_mean[addr];
      return r;
   endfunction

   function automatic event_type make_event(input int energy, input int addr,
                                            input logic [TIMING_W-1:0] timing);
      event_type ev;
      ev.energy          = energy[ENERGY_W-1:0];
      ev.cartridge_index = addr[8];
      ev.fin_index       = addr[7:5];
      ev.module_index    = addr[4:1];
      ev.apd_index       = addr[0];
      ev.timing_word     = timing;
      return ev;
   endfunction

   // Valid stays high from one transfer to the next when no gap is drawn.
   task automatic send_event(input event_type ev);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.energy          <= ev.energy;
      req_bus.cartridge_index <= ev.cartridge_index;
      req_bus.fin_index       <= ev.fin_index;
      req_bus.module_index    <= ev.module_index;
      req_bus.apd_index       <= ev.apd_index;
      req_bus.timing_word     <= ev.timing_word;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_event(ev));
      events_sent++;
   endtask

   task automatic wait_for_idle(input int settle);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [ENERGY_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold_shadow = value;
   endtask

   initial begin : result_checker
      int         stall;
      result_type got, want;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_receiver ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.accepted  = rsp_bus.accepted;
         got.hit_count = rsp_bus.hit_count;
         got.u_average = rsp_bus.u_average;
         got.v_average = rsp_bus.v_average;
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no event outstanding");
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.accepted) updates_seen++;
            if (got.accepted !== want.accepted)
               report_mismatch($sformatf("accepted %0b, expected %0b",
                                         got.accepted, want.accepted));
            if (got.hit_count !== want.hit_count)
               report_mismatch($sformatf("hit_count %0d, expected %0d",
                                         got.hit_count, want.hit_count));
            if (got.u_average !== want.u_average)
               report_mismatch($sformatf("u_average %0d, expected %0d",
                                         got.u_average, want.u_average));
            if (got.v_average !== want.v_average)
               report_mismatch($sformatf("v_average %0d, expected %0d",
                                         got.v_average, want.v_average));
         end
      end
   end

   function automatic logic signed [ENERGY_W-1:0] pick_energy();
      int thr, pick;
      thr  = threshold_shadow;
      pick = $urandom_range(0, 9);
      if (pick < 7 && thr > -32768)
         return 16'(thr - 1 - int'($urandom_range(0, thr + 32767)));
      else if (pick < 9)
         return 16'(thr + int'($urandom_range(0, 32767 - thr)));
      else
         return 16'($urandom);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      unique case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Most events land on a few busy channels so that the means run long.
   function automatic event_type pick_event();
      int addr;
      if ($urandom_range(0, 3) != 0)
         addr = hot_channels[$urandom_range(0, HOT_CHANNELS - 1)];
      else
         addr = $urandom_range(0, TABLE_DEPTH - 1);
      return make_event(pick_energy(), addr, {pick_sample(), pick_sample()});
   endfunction

   task automatic test_reset_threshold();
      send_event(make_event(-701,   0,     32'h7FFF_8000));
      send_event(make_event(-700,   0,     32'h0000_0000));
      send_event(make_event(-32768, 0,     32'h8000_7FFF));
      send_event(make_event(32767,  0,     32'hFFFF_FFFF));
      send_event(make_event(-699,   511,   32'h1234_5678));
      send_event(make_event(-32768, 511,   32'hFFFF_FFFF));
      send_event(make_event(-1000,  511,   32'h0001_FFFE));
      send_event(make_event(-701,   511,   32'h1234_EDCB));
      // Alternating extremes on one channel exercise truncation of both signs.
      for (int i = 0; i < 6; i++)
         send_event(make_event(-2000, 'h155, i[0] ? 32'h8000_7FFF : 32'h7FFF_8000));
      wait_for_idle(SETTLE_CYCLES);
   endtask

   task automatic test_threshold_extremes();
      write_threshold(-16'sd32768);
      send_event(make_event(-32768, 0,   32'h0000_0001));
      send_event(make_event(0,      300, 32'h0001_0000));
      wait_for_idle(SETTLE_CYCLES);
      write_threshold(16'sd32767);
      send_event(make_event(32767,  0,   32'h0000_0000));
      send_event(make_event(32766,  0,   32'h0000_0000));
      send_event(make_event(-32768, 511, 32'h8000_8000));
      wait_for_idle(SETTLE_CYCLES);
      write_threshold(16'sd0);
      send_event(make_event(-1, 300, 32'hFFFF_0001));
      send_event(make_event(0,  300, 32'h0001_FFFF));
      wait_for_idle(SETTLE_CYCLES);
   endtask

   task automatic run_phase(input logic signed [ENERGY_W-1:0] thr, input int items,
                            input bit quiet_tx, input bit quiet_rx, input bit drain_midway);
      write_threshold(thr);
      quiet_sender   = quiet_tx;
      quiet_receiver = quiet_rx;
      for (int i = 0; i < items; i++) begin
         if (drain_midway && i == items / 2) wait_for_idle(0);
         send_event(pick_event());
      end
      wait_for_idle(SETTLE_CYCLES);
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   task automatic test_random_traffic();
      hot_channels[0] = 0;
      hot_channels[1] = TABLE_DEPTH - 1;
      for (int i = 2; i < HOT_CHANNELS; i++)
         hot_channels[i] = $urandom_range(0, TABLE_DEPTH - 1);
      run_phase(THRESHOLD_RESET,  170, 1'b0, 1'b0, 1'b1);
      run_phase(16'sd32767,       170, 1'b1, 1'b1, 1'b0);
      run_phase(16'($urandom),    170, 1'b0, 1'b1, 1'b1);
      run_phase(-16'sd32768,      20,  1'b1, 1'b0, 1'b0);
      run_phase(16'($urandom),    170, 1'b0, 1'b0, 1'b0);
   endtask

   initial begin : stimulus
      reset                   <= 1'b1;
      csr_write_enable        <= 1'b0;
      csr_write_data          <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.energy          <= '0;
      req_bus.cartridge_index <= 1'b0;
      req_bus.fin_index       <= '0;
      req_bus.module_index    <= '0;
      req_bus.apd_index       <= 1'b0;
      req_bus.timing_word     <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         chan_hits[i]   = '0;
         chan_u_mean[i] = '0;
         chan_v_mean[i] = '0;
      end
      threshold_shadow = THRESHOLD_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_threshold();
      test_threshold_extremes();
      test_random_traffic();
      wait_for_idle(TAIL_CYCLES);

      $display("tb: %0d events sent, %0d results checked, %0d channel updates seen",
               events_sent, results_checked, updates_seen);
      $display("tb: thresholds covered reset value, both extremes, zero and random values");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
